/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int ORD_W      = 5;
  localparam int REQ_W      = 17;
  localparam int ADDR_W     = 16;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 40;   // request_size, free_address, zero fill
  localparam int OUT_DATA_W = 24;   // result_address, block_order, zero fill

  localparam logic        OP_FREE     = 1'b1;
  localparam logic [1:0]  STAT_ALLOC  = 2'd0;
  localparam logic [1:0]  STAT_FAIL   = 2'd1;
  localparam logic [1:0]  STAT_FREED  = 2'd2;
  localparam logic [1:0]  STAT_NULL   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_SRCH, ST_POP_RD, ST_POP, ST_SPLIT, ST_REC, ST_FAIL,
    ST_NULL, ST_ORD_RD, ST_ORD, ST_CHECK, ST_WALK_INIT, ST_WALK_TEST, ST_WALK_RD,
    ST_WALK_STEP, ST_PUSH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SRCH, CMD_POP_RD, CMD_POP, CMD_SPLIT, CMD_REC,
    CMD_FAIL, CMD_NULL, CMD_ORD_RD, CMD_ORD, CMD_WALK_INIT, CMD_WALK_RD,
    CMD_WALK_STEP, CMD_PUSH
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic is_free;
    logic is_null;
    logic need_fail;
    logic head_ok_cur;
    logic cur_gt_top;
    logic cur_gt_need;
    logic o_lt_top;
    logic walk_live;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: steps alloc search/split and free merge walks, at most one command a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::cmd_t     cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::ST_IDLE: begin
        if (in_valid && !stat.init_busy) state_next = bba_pkg::ST_DECIDE;
      end
      bba_pkg::ST_DECIDE: begin
        if (stat.is_free) begin
          state_next = stat.is_null ? bba_pkg::ST_NULL : bba_pkg::ST_ORD_RD;
        end else begin
          state_next = stat.need_fail ? bba_pkg::ST_FAIL : bba_pkg::ST_SRCH;
        end
      end
      bba_pkg::ST_SRCH: begin
        if (stat.cur_gt_top) state_next = bba_pkg::ST_FAIL;
        else if (stat.head_ok_cur) state_next = bba_pkg::ST_POP_RD;
      end
      bba_pkg::ST_POP_RD: state_next = bba_pkg::ST_POP;
      bba_pkg::ST_POP:    state_next = bba_pkg::ST_SPLIT;
      bba_pkg::ST_SPLIT: begin
        if (!stat.cur_gt_need) state_next = bba_pkg::ST_REC;
      end
      bba_pkg::ST_REC, bba_pkg::ST_FAIL, bba_pkg::ST_NULL, bba_pkg::ST_PUSH: begin
        if (stat.out_free) state_next = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_ORD_RD: state_next = bba_pkg::ST_ORD;
      bba_pkg::ST_ORD:    state_next = bba_pkg::ST_CHECK;
      bba_pkg::ST_CHECK: begin
        state_next = stat.o_lt_top ? bba_pkg::ST_WALK_INIT : bba_pkg::ST_PUSH;
      end
      bba_pkg::ST_WALK_INIT: state_next = bba_pkg::ST_WALK_TEST;
      bba_pkg::ST_WALK_TEST: begin
        state_next = stat.walk_live ? bba_pkg::ST_WALK_RD : bba_pkg::ST_PUSH;
      end
      bba_pkg::ST_WALK_RD: state_next = bba_pkg::ST_WALK_STEP;
      bba_pkg::ST_WALK_STEP: begin
        state_next = stat.hit ? bba_pkg::ST_CHECK : bba_pkg::ST_WALK_TEST;
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = bba_pkg::CMD_NONE;
    in_ready = 1'b0;
    case (state)
      bba_pkg::ST_IDLE: begin
        in_ready = !stat.init_busy;
        if (in_valid && !stat.init_busy) cmd = bba_pkg::CMD_LOAD;
      end
      bba_pkg::ST_SRCH: begin
        if (!stat.cur_gt_top && !stat.head_ok_cur) cmd = bba_pkg::CMD_SRCH;
      end
      bba_pkg::ST_POP_RD: cmd = bba_pkg::CMD_POP_RD;
      bba_pkg::ST_POP:    cmd = bba_pkg::CMD_POP;
      bba_pkg::ST_SPLIT: begin
        if (stat.cur_gt_need) cmd = bba_pkg::CMD_SPLIT;
      end
      bba_pkg::ST_REC:  if (stat.out_free) cmd = bba_pkg::CMD_REC;
      bba_pkg::ST_FAIL: if (stat.out_free) cmd = bba_pkg::CMD_FAIL;
      bba_pkg::ST_NULL: if (stat.out_free) cmd = bba_pkg::CMD_NULL;
      bba_pkg::ST_PUSH: if (stat.out_free) cmd = bba_pkg::CMD_PUSH;
      bba_pkg::ST_ORD_RD:    cmd = bba_pkg::CMD_ORD_RD;
      bba_pkg::ST_ORD:       cmd = bba_pkg::CMD_ORD;
      bba_pkg::ST_WALK_INIT: cmd = bba_pkg::CMD_WALK_INIT;
      bba_pkg::ST_WALK_RD:   cmd = bba_pkg::CMD_WALK_RD;
      bba_pkg::ST_WALK_STEP: cmd = bba_pkg::CMD_WALK_STEP;
      default: cmd = bba_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bba_dp.sv */
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: list heads, link and order RAMs, walk registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
  parameter int POOL_ORDER   = 16,
  parameter int MIN_ORDER    = 3,
  parameter int HEADER_BYTES = 4
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [bba_pkg::ORD_W-1:0]           cfg_wdata,
  input  wire [bba_pkg::IN_DATA_W-1:0]       in_data,
  input  wire                                in_op,
  input  bba_pkg::cmd_t                      cmd,
  output bba_pkg::dp_stat_t                  stat,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [bba_pkg::STAT_W-1:0]         out_status,
  output logic [bba_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int GW  = POOL_ORDER - MIN_ORDER;
  localparam int HIW = $clog2(POOL_ORDER + 1);
  localparam int AW  = (POOL_ORDER > bba_pkg::ADDR_W) ? POOL_ORDER : bba_pkg::ADDR_W;
  localparam int TW  = bba_pkg::REQ_W + 1;
  localparam int OW  = bba_pkg::ORD_W;

  // control
  logic                 init_wr;
  logic [POOL_ORDER:0]  head_ok;
  logic                 walk_ok;
  logic                 have_prev;
  logic [GW:0]          steps;
  // payload
  logic [GW-1:0]        head [POOL_ORDER+1];
  logic [OW-1:0]        top_order;
  logic                 op_free;
  logic                 null_f;
  logic [OW-1:0]        need;
  logic [OW-1:0]        cur;
  logic [OW-1:0]        ord;
  logic [GW-1:0]        gran;
  logic [GW-1:0]        offg;
  logic [GW-1:0]        target;
  logic [GW-1:0]        walk_cur;
  logic [GW-1:0]        prev;
  logic [bba_pkg::STAT_W-1:0] res_status;
  logic [bba_pkg::ADDR_W-1:0] res_addr;
  logic [OW-1:0]        res_ord;

  // RAM ports
  logic                 lk_we;
  logic [GW-1:0]        lk_waddr;
  logic [GW:0]          lk_wdata;
  logic [GW-1:0]        lk_raddr;
  logic [GW:0]          lk_rdata;
  logic                 or_we;
  logic [OW-1:0]        or_rdata;

  // combinational helpers
  logic [bba_pkg::REQ_W-1:0]  in_size;
  logic [bba_pkg::ADDR_W-1:0] in_faddr;
  logic [TW-1:0]        total;
  logic [TW-1:0]        tm1;
  logic [OW-1:0]        need_c;
  logic [AW-1:0]        offb;
  logic [GW:0]          gone;
  logic [GW-1:0]        gmask;
  logic [GW-1:0]        offg_c;
  logic [OW-1:0]        cdec;
  logic [GW-1:0]        split_g;
  logic [OW-1:0]        ord_c;
  logic [GW:0]          aone;
  logic [GW-1:0]        buddy;
  logic [AW-1:0]        gbytes;
  logic [OW-1:0]        cfg_sat;

  assign in_size  = in_data[bba_pkg::REQ_W-1:0];
  assign in_faddr = in_data[bba_pkg::REQ_W +: bba_pkg::ADDR_W];

  always_comb begin
    total = TW'(in_size) + TW'(HEADER_BYTES);
    tm1   = total - TW'(1);
    need_c = '0;
    for (int i = 0; i < TW; i++) begin
      if (tm1[i]) need_c = OW'(i + 1);
    end
    if (need_c < OW'(MIN_ORDER)) need_c = OW'(MIN_ORDER);

    gone   = (GW+1)'(1) << (top_order - OW'(MIN_ORDER));
    gmask  = GW'(gone - (GW+1)'(1));
    offb   = AW'(in_faddr) - AW'(HEADER_BYTES);
    offg_c = offb[POOL_ORDER-1:MIN_ORDER] & gmask;

    cdec    = cur - OW'(1);
    split_g = gran + (GW'(1) << (cdec - OW'(MIN_ORDER)));

    ord_c = or_rdata;
    if (ord_c < OW'(MIN_ORDER)) ord_c = OW'(MIN_ORDER);
    if (ord_c > top_order) ord_c = top_order;
    aone  = (GW+1)'(1) << (ord_c - OW'(MIN_ORDER));

    buddy  = (offg ^ (GW'(1) << (ord - OW'(MIN_ORDER)))) & gmask;
    gbytes = AW'(gran) << MIN_ORDER;

    cfg_sat = cfg_wdata;
    if (cfg_sat < OW'(MIN_ORDER)) cfg_sat = OW'(MIN_ORDER);
    if (cfg_sat > OW'(POOL_ORDER)) cfg_sat = OW'(POOL_ORDER);
  end

  // status to the sequencer
  always_comb begin
    stat.init_busy   = init_wr;
    stat.is_free     = op_free;
    stat.is_null     = null_f;
    stat.need_fail   = need > top_order;
    stat.head_ok_cur = (cur <= top_order) && head_ok[cur[HIW-1:0]];
    stat.cur_gt_top  = cur > top_order;
    stat.cur_gt_need = cur > need;
    stat.o_lt_top    = ord < top_order;
    stat.walk_live   = walk_ok && (steps <= {1'b1, {GW{1'b0}}});
    stat.hit         = walk_cur == target;
    stat.out_free    = !out_valid || out_ready;
  end

  // link RAM ports
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    lk_raddr = walk_cur;
    if (init_wr) begin
      lk_we = 1'b1;
    end else begin
      case (cmd)
        bba_pkg::CMD_SPLIT: begin
          lk_we    = 1'b1;
          lk_waddr = split_g;
          lk_wdata = {head_ok[cdec[HIW-1:0]], head[cdec[HIW-1:0]]};
        end
        bba_pkg::CMD_WALK_STEP: begin
          lk_we    = (walk_cur == target) && have_prev;
          lk_waddr = prev;
          lk_wdata = lk_rdata;
        end
        bba_pkg::CMD_PUSH: begin
          lk_we    = 1'b1;
          lk_waddr = offg;
          lk_wdata = {head_ok[ord[HIW-1:0]], head[ord[HIW-1:0]]};
        end
        default: lk_we = 1'b0;
      endcase
    end
    if (cmd == bba_pkg::CMD_POP_RD) lk_raddr = head[cur[HIW-1:0]];
  end

  assign or_we = (cmd == bba_pkg::CMD_REC);

  bba_ram #(.WIDTH(GW + 1), .DEPTH(2 ** GW)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  bba_ram #(.WIDTH(OW), .DEPTH(2 ** GW)) u_order_ram (
    .clk   (clk),
    .we    (or_we),
    .waddr (gran),
    .wdata (need),
    .raddr (offg),
    .rdata (or_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_wr   <= 1'b1;
      head_ok   <= '0;
      head_ok[POOL_ORDER] <= 1'b1;
      head[POOL_ORDER]    <= '0;
      top_order <= OW'(POOL_ORDER);
      out_valid <= 1'b0;
      walk_ok   <= 1'b0;
      have_prev <= 1'b0;
      steps     <= '0;
    end else begin
      init_wr <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        // reinitialize: one free block of order top_order at offset 0
        init_wr   <= 1'b1;
        top_order <= cfg_sat;
        head_ok   <= '0;
        head_ok[cfg_sat[HIW-1:0]] <= 1'b1;
        head[cfg_sat[HIW-1:0]]    <= '0;
      end
      case (cmd)
        bba_pkg::CMD_LOAD: begin
          op_free <= (in_op == bba_pkg::OP_FREE);
          null_f  <= (in_faddr == '0);
          need    <= need_c;
          cur     <= need_c;
          offg    <= offg_c;
        end
        bba_pkg::CMD_SRCH: cur <= cur + OW'(1);
        bba_pkg::CMD_POP_RD: gran <= head[cur[HIW-1:0]];
        bba_pkg::CMD_POP: begin
          head[cur[HIW-1:0]]    <= lk_rdata[GW-1:0];
          head_ok[cur[HIW-1:0]] <= lk_rdata[GW];
        end
        bba_pkg::CMD_SPLIT: begin
          cur <= cdec;
          head[cdec[HIW-1:0]]    <= split_g;
          head_ok[cdec[HIW-1:0]] <= 1'b1;
        end
        bba_pkg::CMD_REC: begin
          out_valid  <= 1'b1;
          res_status <= bba_pkg::STAT_ALLOC;
          res_addr   <= gbytes[bba_pkg::ADDR_W-1:0] + bba_pkg::ADDR_W'(HEADER_BYTES);
          res_ord    <= need;
        end
        bba_pkg::CMD_FAIL: begin
          out_valid  <= 1'b1;
          res_status <= bba_pkg::STAT_FAIL;
          res_addr   <= '0;
          res_ord    <= '0;
        end
        bba_pkg::CMD_NULL: begin
          out_valid  <= 1'b1;
          res_status <= bba_pkg::STAT_NULL;
          res_addr   <= '0;
          res_ord    <= '0;
        end
        bba_pkg::CMD_ORD: begin
          ord  <= ord_c;
          offg <= offg & ~GW'(aone - (GW+1)'(1));
        end
        bba_pkg::CMD_WALK_INIT: begin
          target    <= buddy;
          walk_cur  <= head[ord[HIW-1:0]];
          walk_ok   <= head_ok[ord[HIW-1:0]];
          have_prev <= 1'b0;
          steps     <= '0;
        end
        bba_pkg::CMD_WALK_STEP: begin
          if (walk_cur == target) begin
            // unlink the buddy and merge toward the lower address
            if (!have_prev) begin
              head[ord[HIW-1:0]]    <= lk_rdata[GW-1:0];
              head_ok[ord[HIW-1:0]] <= lk_rdata[GW];
            end
            if (target < offg) offg <= target;
            ord <= ord + OW'(1);
          end else begin
            prev      <= walk_cur;
            have_prev <= 1'b1;
            walk_ok   <= lk_rdata[GW];
            walk_cur  <= lk_rdata[GW-1:0];
            steps     <= steps + (GW+1)'(1);
          end
        end
        bba_pkg::CMD_PUSH: begin
          head[ord[HIW-1:0]]    <= offg;
          head_ok[ord[HIW-1:0]] <= 1'b1;
          out_valid  <= 1'b1;
          res_status <= bba_pkg::STAT_FREED;
          res_addr   <= '0;
          res_ord    <= ord;
        end
        default: ;
      endcase
    end
  end

  assign out_status = res_status;
  assign out_data   = {3'b000, res_ord, res_addr};

endmodule

`default_nettype wire

/* hw/rtl/buddy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator with per-order LIFO free lists over a power-of-two pool.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tdata: request_size[16:0], free_address[32:17]; tuser: op
//  m_*     | out | tdata: result_address[15:0], block_order[20:16]; tuser: status
//  cfg_*   | in  | top_order write, reinitializes the pool
//
// Alloc: load, decide, search upward one order at a time, pop read, pop, one split
// per order down to need, record. Free: load, decide, order read, order, then per
// order a list walk for the buddy, merging on a hit. Null free or early fail goes
// straight to its result. Each walk step costs a registered read of the link RAM.
// Reset (and each top_order write) seeds the link of granule 0 before requests are taken.
// The result register frees the request side; a stalled result holds the next
// request in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_unit #(
  parameter int POOL_ORDER   = 16,
  parameter int MIN_ORDER    = 3,
  parameter int HEADER_BYTES = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [bba_pkg::ORD_W-1:0]          cfg_wdata,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [bba_pkg::IN_DATA_W-1:0]      s_tdata,   // request_size, free_address
  input  wire                               s_tuser,   // op
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]    m_tdata,   // result_address, block_order
  output logic [bba_pkg::STAT_W-1:0]        m_tuser    // status
);

  bba_pkg::cmd_t     cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .POOL_ORDER   (POOL_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_data    (s_tdata),
    .in_op      (s_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("request taken during pool reinit");

  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
